[hdl/fire_spread_grid_step_unit_macros.svh]
// Assertion macros shared by the fire spread grid step unit.
`ifndef FIRE_SPREAD_GRID_STEP_UNIT_MACROS_SVH
`define FIRE_SPREAD_GRID_STEP_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FSG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define FSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/fsg_pkg.sv]
package fsg_pkg;

  // Grid storage geometry.
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int DIM_W    = 7;
  localparam int SEED_W   = 16;
  localparam int CFG_W    = 16;

  // Cell codes.
  localparam logic [1:0] CELL_INERT   = 2'd0;
  localparam logic [1:0] CELL_TREE    = 2'd1;
  localparam logic [1:0] CELL_BURNING = 2'd2;

  localparam logic [1:0] STALL_LIMIT = 2'd3;
  localparam logic [SEED_W-1:0] DEFAULT_SEED = 16'd44257;

  // Operation codes.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;
  localparam logic [1:0] CFG_SEED = 2'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [1:0]       cell_in;
  } cmd_t;

  typedef struct packed {
    logic [1:0] cell_out;
    logic       changed;
    logic       ended;
    logic [1:0] stall_count;
  } result_t;

endpackage

[hdl/fire_spread_grid_step_unit.sv]
// Forest fire grid step unit.
// A command is transferred at a rising edge where start is high and busy is low.
// cmd.op selects a cell write, a cell read or one generation step; row and col
// address the cell for write and read. Every command gives exactly one result,
// shown on result for the single cycle in which done is high; the receiver
// cannot hold it off and must take it in that cycle.
// Write, read and the unused op code give their result in the cycle after the
// command transfer, and a new command may be transferred in that same cycle.
// A step sweeps the whole storage array through the cell memory, one cell per
// cycle, through a window of two rows plus two cells; busy stays high for the
// whole sweep and the result follows with done as busy falls. The memory read
// and write ports, one cell each per cycle, set the length of the sweep.
// The user writes configuration through cfg_we, cfg_index and cfg_data only
// while idle; the block does not enforce it. A seed write also reloads the generator.
// Reset (rst, synchronous) returns to idle with 64 by 64 cells in use, the
// default seed, bank zero current and the stagnation count zero. Grid contents
// are not cleared and must be written before they are read or stepped over.
`include "fire_spread_grid_step_unit_macros.svh"

module fire_spread_grid_step_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  fsg_pkg::cmd_t                cmd,
  output logic                         done,
  output fsg_pkg::result_t             result,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [fsg_pkg::CFG_W-1:0]    cfg_data
);

  // Sweep timing: the read address runs ahead of the decided cell by one row
  // and two cells (one for the memory latency, the rest for the window).
  localparam int LAG   = fsg_pkg::MAX_COLS + 2;
  localparam int LAST  = fsg_pkg::CELLS + LAG - 1;
  localparam int CNT_W = $clog2(LAST + 1);
  localparam int WIN   = 2 * fsg_pkg::MAX_COLS + 2;
  localparam int C     = fsg_pkg::MAX_COLS;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_STEP = 1'b1;

  logic                        state;
  logic                        active;
  logic [CNT_W-1:0]            cnt;
  logic                        chg;
  logic [1:0]                  stall;
  logic [fsg_pkg::SEED_W-1:0]  lfsr;
  logic [fsg_pkg::DIM_W-1:0]   grid_rows;
  logic [fsg_pkg::DIM_W-1:0]   grid_cols;
  logic                        res_read;
  logic                        res_changed;
  logic                        res_ended;

  // Both banks live in one memory; the top address bit is the bank.
  logic [1:0] mem [0:2*fsg_pkg::CELLS-1];
  logic [1:0] rd_q;
  logic [fsg_pkg::ADDR_W:0] raddr;
  logic [fsg_pkg::ADDR_W:0] waddr;
  logic [1:0]               wdata;
  logic                     we;

  // Window of the cells streamed out of the current bank.
  logic [1:0] win [0:WIN-1];

  logic                        accept;
  logic [1:0]                  feed;
  logic                        decide;
  logic [fsg_pkg::ADDR_W-1:0]  m;
  logic [fsg_pkg::ROW_W-1:0]   mr;
  logic [fsg_pkg::COL_W-1:0]   mc;
  logic [fsg_pkg::DIM_W-1:0]   rows_eff;
  logic [fsg_pkg::DIM_W-1:0]   cols_eff;
  logic                        in_grid;
  logic                        up_ok;
  logic                        down_ok;
  logic                        left_ok;
  logic                        right_ok;
  logic                        near_fire;
  logic                        candidate;
  logic                        lfsr_fb;
  logic [fsg_pkg::SEED_W-1:0]  lfsr_next;
  logic                        ignite;
  logic [1:0]                  new_v;
  logic                        chg_any;
  logic [fsg_pkg::SEED_W-1:0]  seed_val;

  assign busy   = (state == ST_STEP);
  assign accept = start && (state == ST_IDLE);

  // Cells beyond the storage array act as the array limit.
  assign rows_eff = (grid_rows > fsg_pkg::DIM_W'(fsg_pkg::MAX_ROWS)) ?
                    fsg_pkg::DIM_W'(fsg_pkg::MAX_ROWS) : grid_rows;
  assign cols_eff = (grid_cols > fsg_pkg::DIM_W'(fsg_pkg::MAX_COLS)) ?
                    fsg_pkg::DIM_W'(fsg_pkg::MAX_COLS) : grid_cols;

  // The cell entering the window this cycle was read in the previous one;
  // past the end of the array the stream is padded with inert cells.
  assign feed = (cnt <= CNT_W'(fsg_pkg::CELLS)) ? rd_q : fsg_pkg::CELL_INERT;

  // The decided cell sits in the middle of the window.
  assign decide = busy && (cnt >= CNT_W'(LAG));
  assign m      = fsg_pkg::ADDR_W'(cnt - CNT_W'(LAG));
  assign mr     = m[fsg_pkg::ADDR_W-1:fsg_pkg::COL_W];
  assign mc     = m[fsg_pkg::COL_W-1:0];

  assign in_grid  = ({1'b0, mr} < rows_eff) && ({1'b0, mc} < cols_eff);
  assign up_ok    = (mr != '0);
  assign down_ok  = (({1'b0, mr} + fsg_pkg::DIM_W'(1)) < rows_eff);
  assign left_ok  = (mc != '0);
  assign right_ok = (({1'b0, mc} + fsg_pkg::DIM_W'(1)) < cols_eff);

  // Neighbours that fall outside the grid in use are masked off, which also
  // hides the wrap from one row end into the next.
  always_comb begin
    near_fire = 1'b0;
    if (up_ok && left_ok && win[2*C+1] == fsg_pkg::CELL_BURNING) near_fire = 1'b1;
    if (up_ok && win[2*C] == fsg_pkg::CELL_BURNING) near_fire = 1'b1;
    if (up_ok && right_ok && win[2*C-1] == fsg_pkg::CELL_BURNING) near_fire = 1'b1;
    if (left_ok && win[C+1] == fsg_pkg::CELL_BURNING) near_fire = 1'b1;
    if (right_ok && win[C-1] == fsg_pkg::CELL_BURNING) near_fire = 1'b1;
    if (down_ok && left_ok && win[1] == fsg_pkg::CELL_BURNING) near_fire = 1'b1;
    if (down_ok && win[0] == fsg_pkg::CELL_BURNING) near_fire = 1'b1;
    if (down_ok && right_ok && feed == fsg_pkg::CELL_BURNING) near_fire = 1'b1;
  end

  // The generator advances once per tree with a burning neighbour, in sweep
  // order, and the tree ignites on the new low bit.
  assign candidate = decide && in_grid && (win[C] == fsg_pkg::CELL_TREE) && near_fire;
  assign lfsr_fb   = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
  assign lfsr_next = {lfsr_fb, lfsr[fsg_pkg::SEED_W-1:1]};
  assign ignite    = candidate && lfsr_next[0];
  assign new_v     = ignite ? fsg_pkg::CELL_BURNING : win[C];
  assign chg_any   = chg || ignite;

  assign seed_val = (cfg_data[fsg_pkg::SEED_W-1:0] == '0) ? fsg_pkg::DEFAULT_SEED :
                    cfg_data[fsg_pkg::SEED_W-1:0];

  // Memory address and write selection.
  always_comb begin
    raddr = {active, cmd.row, cmd.col};
    waddr = {active, cmd.row, cmd.col};
    wdata = cmd.cell_in;
    we    = 1'b0;
    if (busy) begin
      raddr = {active, cnt[fsg_pkg::ADDR_W-1:0]};
      waddr = {~active, m};
      wdata = new_v;
      we    = decide;
    end else if (accept && cmd.op == fsg_pkg::OP_WRITE) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (busy && cnt != '0) begin
      win[0] <= feed;
      for (int i = 1; i < WIN; i++) begin
        win[i] <= win[i-1];
      end
    end
  end

  // Configuration registers and the random generator.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= fsg_pkg::DIM_W'(fsg_pkg::MAX_ROWS);
      grid_cols <= fsg_pkg::DIM_W'(fsg_pkg::MAX_COLS);
      lfsr      <= fsg_pkg::DEFAULT_SEED;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fsg_pkg::CFG_ROWS: grid_rows <= cfg_data[fsg_pkg::DIM_W-1:0];
          fsg_pkg::CFG_COLS: grid_cols <= cfg_data[fsg_pkg::DIM_W-1:0];
          fsg_pkg::CFG_SEED: lfsr <= seed_val;
          default: ;
        endcase
      end
      if (candidate) begin
        lfsr <= lfsr_next;
      end
    end
  end

  // Command sequencing and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      active      <= 1'b0;
      cnt         <= '0;
      chg         <= 1'b0;
      stall       <= '0;
      done        <= 1'b0;
      res_read    <= 1'b0;
      res_changed <= 1'b0;
      res_ended   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_read    <= (cmd.op == fsg_pkg::OP_READ);
            res_changed <= 1'b0;
            res_ended   <= 1'b0;
            if (cmd.op == fsg_pkg::OP_STEP) begin
              state <= ST_STEP;
              cnt   <= '0;
              chg   <= 1'b0;
            end else begin
              done <= 1'b1;
            end
          end
        end
        ST_STEP: begin
          chg <= chg_any;
          if (cnt == CNT_W'(LAST)) begin
            state       <= ST_IDLE;
            active      <= ~active;
            done        <= 1'b1;
            res_read    <= 1'b0;
            res_changed <= chg_any;
            res_ended   <= !chg_any && (stall == fsg_pkg::STALL_LIMIT);
            if (!chg_any && stall != fsg_pkg::STALL_LIMIT) begin
              stall <= stall + 2'd1;
            end
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign result.cell_out    = res_read ? rd_q : fsg_pkg::CELL_INERT;
  assign result.changed     = res_changed;
  assign result.ended       = res_ended;
  assign result.stall_count = stall;

  `FSG_ASSERT_NOW(a_done_when_idle, done, !busy, "result shown while a step is running")
  `FSG_ASSERT_NEXT(a_step_starts, accept && cmd.op == fsg_pkg::OP_STEP, busy && !done, "step did not start")
  `FSG_ASSERT_NEXT(a_quick_ops_done, accept && cmd.op != fsg_pkg::OP_STEP, done && !busy, "missing result")
  `FSG_ASSERT_NOW(a_end_needs_stall, done && result.ended, !result.changed && stall == fsg_pkg::STALL_LIMIT, "end flag without full stagnation")
  `FSG_ASSERT_NEXT(a_stall_keeps, stall != 2'd0, stall != 2'd0, "stagnation count fell back")

endmodule
